>>> src/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// shared types, constants and the cordic arctangent table for the
// differential drive odometry integrator
// ----------------------------------------------------------------------------
`default_nettype none

package odo_pkg;

	localparam int DEF_VEL_BITS     = 16;
	localparam int DEF_CORDIC_STEPS = 24;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_MPT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WB  = 1'b1;

	localparam logic [23:0] MPT_RESET = 24'd47436;
	localparam logic [23:0] WB_RESET  = 24'd34079;

	// 2^32 / (2 pi)
	localparam logic [29:0] INV_TWO_PI  = 30'd683565276;
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;
	localparam int ARC_MIN = 684;

	// cordic datapath width, q1.30 with headroom
	localparam int CW = 34;

	// divider quotient bits for the turn rate and the arc factors
	localparam int QUO_BITS  = 41;
	localparam int ARC_QBITS = 32;
	localparam int DIV_CNT_W = 6;

	typedef enum logic {
		DIV_ANG = 1'b0,
		DIV_ARC = 1'b1
	} div_mode_t;

	typedef struct packed {
		logic      start;
		div_mode_t mode;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic                ovf;
		logic [QUO_BITS-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic                 done;
		logic signed [CW-1:0] cos;
		logic signed [CW-1:0] sin;
	} cordic_res_t;

	function automatic logic [29:0] atan_entry(input logic [4:0] idx);
		logic [29:0] v;
		unique case (idx)
			5'd0:  v = 30'd536870912;
			5'd1:  v = 30'd316933406;
			5'd2:  v = 30'd167458907;
			5'd3:  v = 30'd85004756;
			5'd4:  v = 30'd42667331;
			5'd5:  v = 30'd21354465;
			5'd6:  v = 30'd10679838;
			5'd7:  v = 30'd5340245;
			5'd8:  v = 30'd2670163;
			5'd9:  v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			5'd30: v = 30'd1;
			5'd31: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> src/diff_drive_odometry_integrator.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator
// wheel odometry integrator: four encoder rates per transaction in, updated
// pose, heading quaternion and per-tick motion out
//
// input transaction: in_valid with the four wheel rates, taken when in_stall
// is low. in_stall stays high while a tick is being worked on.
// output transaction: out_valid with the pose fields, held until out_stall is
// low. the result sits in an output register, so the next tick is taken while
// it waits; a tick only finishes once that register is free.
// each tick runs a bit-serial turn-rate divide, then two cordic runs when the
// turn is below the arc threshold, or three cordic runs and two arc-factor
// divides otherwise. one multiplier, one divider and one cordic are shared.
// cfg_write loads meters_per_tick (index 0) or wheel_base (index 1); the user
// must write it only while idle, which the block itself does not enforce.
// reset clears pose and heading, loads the default registers and drops
// out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module diff_drive_odometry_integrator #(
	parameter int VEL_BITS     = odo_pkg::DEF_VEL_BITS,
	parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write,
	input  wire logic [odo_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [odo_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic signed [VEL_BITS-1:0]      vel_left_front,
	input  wire logic signed [VEL_BITS-1:0]      vel_right_front,
	input  wire logic signed [VEL_BITS-1:0]      vel_left_rear,
	input  wire logic signed [VEL_BITS-1:0]      vel_right_rear,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [31:0]                   pos_x,
	output logic signed [31:0]                   pos_y,
	output logic [31:0]                          heading_angle,
	output logic signed [15:0]                   quat_z,
	output logic signed [15:0]                   quat_w,
	output logic signed [31:0]                   linear_step,
	output logic signed [31:0]                   angular_step
);
	import odo_pkg::*;

	localparam int SW   = VEL_BITS + 2;
	localparam int DW   = VEL_BITS + 3;
	localparam int MAGW = VEL_BITS + 25;
	localparam int MHW  = MAGW - 24;
	localparam int DVW  = (VEL_BITS + 55 > 64) ? VEL_BITS + 55 : 64;
	localparam int MA   = (VEL_BITS + 3 > 35) ? VEL_BITS + 3 : 35;
	localparam int MB   = 34;
	localparam int PW   = MA + MB;

	typedef enum logic [20:0] {
		ST_IDLE        = 21'h000001,
		ST_MUL_LIN     = 21'h000002,
		ST_MUL_MAG     = 21'h000004,
		ST_MUL_NH      = 21'h000008,
		ST_MUL_NL      = 21'h000010,
		ST_ANG_GO      = 21'h000020,
		ST_ANG_WAIT    = 21'h000040,
		ST_BRANCH      = 21'h000080,
		ST_RK_WAIT     = 21'h000100,
		ST_ARC0_WAIT   = 21'h000200,
		ST_ARC1_WAIT   = 21'h000400,
		ST_ARC_MFY     = 21'h000800,
		ST_ARC_DX_GO   = 21'h001000,
		ST_ARC_DX_WAIT = 21'h002000,
		ST_ARC_DY_WAIT = 21'h004000,
		ST_MX          = 21'h008000,
		ST_MY          = 21'h010000,
		ST_SY          = 21'h020000,
		ST_UPDATE      = 21'h040000,
		ST_QWAIT       = 21'h080000,
		ST_FINISH      = 21'h100000
	} state_t;

	state_t state_q, state_d;

	logic [23:0] mpt_q, wb_q;
	logic [31:0] x_q, y_q, h_q;
	logic        out_valid_q;

	logic signed [SW-1:0]   sum_q;
	logic signed [DW-1:0]   dif_q;
	logic signed [31:0]     lin_q;
	logic [23:0]            mag_lo_q;
	logic [DVW-1:0]         nacc_q;
	logic signed [31:0]     ang_q;
	logic [31:0]            h1_q;
	logic signed [CW-1:0]   c0_q, s0_q, c1_q;
	logic signed [PW-1:0]   numx_q, numy_q;
	logic signed [32:0]     fx_q, fy_q;
	logic [31:0]            dx_q, dy_q;
	logic signed [PW-1:0]   prod_q;

	logic signed [31:0] pos_x_q, pos_y_q, lin_out_q, ang_out_q;
	logic [31:0]        head_q;
	logic signed [15:0] qz_q, qw_q;

	logic signed [DW-1:0] lf_e, rf_e, lr_e, rr_e, sl, sr, sum_in, dif_in, dif_abs;
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic signed [PW-1:0] lin_t, rnd_t, numx_abs, numy_abs;
	logic                 lin_ok;
	logic signed [31:0]   lin_v;
	logic [23:0]          wb_eff;
	logic [MAGW-1:0]      mag;
	logic [41:0]          a42;
	logic [32:0]          amag;
	logic [30:0]          mag31;
	logic signed [31:0]   ang_v;
	logic                 rk_path;
	logic [30:0]          ang_abs;
	logic [31:0]          fmag;
	logic signed [32:0]   fmag_s, f_v;
	logic                 f_neg;
	logic signed [CW:0]   s_dif, c_dif;
	logic                 out_free;

	div_req_t          div_req;
	logic [DVW-1:0]    div_dividend;
	logic [30:0]       div_divisor;
	div_res_t          div_res;
	logic              cor_start;
	logic [31:0]       cor_angle;
	cordic_res_t       cor_res;

	function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		logic                 ok;
		t  = (v + CW'(16384)) >>> 15;
		ok = (t[CW-1:15] == '0) || (t[CW-1:15] == '1);
		return ok ? t[15:0] : (t[CW-1] ? 16'sh8000 : 16'sh7fff);
	endfunction

	odo_div #(
		.DIVIDEND_BITS(DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	odo_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.angle  (cor_angle),
		.res    (cor_res)
	);

	always_comb begin
		lf_e    = DW'(vel_left_front);
		rf_e    = DW'(vel_right_front);
		lr_e    = DW'(vel_left_rear);
		rr_e    = DW'(vel_right_rear);
		sl      = lf_e + lr_e;
		sr      = -(rf_e + rr_e);
		sum_in  = sl + sr;
		dif_in  = sr - sl;
		dif_abs = dif_q[DW-1] ? -dif_q : dif_q;
		wb_eff  = (wb_q == '0) ? 24'd1 : wb_q;
		mag     = prod_q[MAGW-1:0];
		out_free = !out_valid_q || !out_stall;

		lin_t  = (prod_q + PW'(512)) >>> 10;
		lin_ok = (lin_t[PW-1:31] == '0) || (lin_t[PW-1:31] == '1);
		lin_v  = lin_ok ? lin_t[31:0] : (lin_t[PW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff);

		rnd_t = prod_q + PW'(32'sd536870912);

		a42   = {1'b0, div_res.quo} + 42'd256;
		amag  = a42[41:9];
		mag31 = (div_res.ovf || amag[32:31] != 2'b00) ? 31'h7fff_ffff : amag[30:0];
		ang_v = dif_q[DW-1] ? -$signed({1'b0, mag31}) : $signed({1'b0, mag31});

		rk_path = (ang_q < 32'sd684) && (ang_q > -32'sd684);
		ang_abs = ang_q[31] ? 31'(-ang_q) : ang_q[30:0];

		numx_abs = numx_q[PW-1] ? -numx_q : numx_q;
		numy_abs = numy_q[PW-1] ? -numy_q : numy_q;
		f_neg    = (state_q == ST_ARC_DX_WAIT) ? (numx_q[PW-1] ^ ang_q[31])
		                                       : (numy_q[PW-1] ^ ang_q[31]);
		fmag     = div_res.quo[31:0];
		fmag_s   = (div_res.ovf || fmag[31]) ? 33'sh0_8000_0000 : $signed({1'b0, fmag});
		f_v      = f_neg ? -fmag_s : fmag_s;

		s_dif = (CW+1)'(cor_res.sin) - (CW+1)'(s0_q);
		c_dif = (CW+1)'(c0_q) - (CW+1)'(c1_q);
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_MUL_LIN: begin
				mul_a = MA'(sum_q);
				mul_b = MB'($signed({1'b0, mpt_q}));
			end
			ST_MUL_MAG: begin
				mul_a = MA'(dif_abs);
				mul_b = MB'($signed({1'b0, mpt_q}));
			end
			ST_MUL_NH: begin
				mul_a = MA'($signed({1'b0, mag[MAGW-1:24]}));
				mul_b = MB'($signed({1'b0, INV_TWO_PI}));
			end
			ST_MUL_NL: begin
				mul_a = MA'($signed({1'b0, mag_lo_q}));
				mul_b = MB'($signed({1'b0, INV_TWO_PI}));
			end
			ST_ARC1_WAIT: begin
				mul_a = MA'(s_dif);
				mul_b = MB'($signed({1'b0, INV_TWO_PI}));
			end
			ST_ARC_MFY: begin
				mul_a = MA'(c_dif);
				mul_b = MB'($signed({1'b0, INV_TWO_PI}));
			end
			ST_MX: begin
				mul_a = MA'(lin_q);
				mul_b = MB'(fx_q);
			end
			ST_MY: begin
				mul_a = MA'(lin_q);
				mul_b = MB'(fy_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divider and cordic requests
	always_comb begin
		div_req.start = 1'b0;
		div_req.mode  = DIV_ANG;
		div_dividend  = '0;
		div_divisor   = 31'(wb_eff);
		cor_start     = 1'b0;
		cor_angle     = h_q;
		unique case (state_q)
			ST_ANG_GO: begin
				div_req.start = 1'b1;
				div_dividend  = nacc_q + DVW'(prod_q[53:0]);
			end
			ST_ARC_DX_GO: begin
				div_req.start = 1'b1;
				div_req.mode  = DIV_ARC;
				div_dividend  = DVW'(numx_abs);
				div_divisor   = ang_abs;
			end
			ST_ARC_DX_WAIT: begin
				div_req.start = div_res.done;
				div_req.mode  = DIV_ARC;
				div_dividend  = DVW'(numy_abs);
				div_divisor   = ang_abs;
			end
			ST_ARC_DY_WAIT: begin
				div_req.mode = DIV_ARC;
				div_divisor  = ang_abs;
			end
			ST_BRANCH: begin
				cor_start = 1'b1;
				cor_angle = rk_path ? h_q + {ang_q[31], ang_q[31:1]} : h_q;
			end
			ST_ARC0_WAIT: begin
				cor_start = cor_res.done;
				cor_angle = h1_q;
			end
			ST_UPDATE: begin
				cor_start = 1'b1;
				cor_angle = {1'b0, h1_q[31:1]};
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:        if (in_valid) state_d = ST_MUL_LIN;
			ST_MUL_LIN:     state_d = ST_MUL_MAG;
			ST_MUL_MAG:     state_d = ST_MUL_NH;
			ST_MUL_NH:      state_d = ST_MUL_NL;
			ST_MUL_NL:      state_d = ST_ANG_GO;
			ST_ANG_GO:      state_d = ST_ANG_WAIT;
			ST_ANG_WAIT:    if (div_res.done) state_d = ST_BRANCH;
			ST_BRANCH:      state_d = rk_path ? ST_RK_WAIT : ST_ARC0_WAIT;
			ST_RK_WAIT:     if (cor_res.done) state_d = ST_MX;
			ST_ARC0_WAIT:   if (cor_res.done) state_d = ST_ARC1_WAIT;
			ST_ARC1_WAIT:   if (cor_res.done) state_d = ST_ARC_MFY;
			ST_ARC_MFY:     state_d = ST_ARC_DX_GO;
			ST_ARC_DX_GO:   state_d = ST_ARC_DX_WAIT;
			ST_ARC_DX_WAIT: if (div_res.done) state_d = ST_ARC_DY_WAIT;
			ST_ARC_DY_WAIT: if (div_res.done) state_d = ST_MX;
			ST_MX:          state_d = ST_MY;
			ST_MY:          state_d = ST_SY;
			ST_SY:          state_d = ST_UPDATE;
			ST_UPDATE:      state_d = ST_QWAIT;
			ST_QWAIT:       if (cor_res.done) state_d = ST_FINISH;
			ST_FINISH:      if (out_free) state_d = ST_IDLE;
			default:        state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mpt_q       <= MPT_RESET;
			wb_q        <= WB_RESET;
			x_q         <= '0;
			y_q         <= '0;
			h_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				if (cfg_index == REG_MPT) begin
					mpt_q <= cfg_data;
				end else if (cfg_index == REG_WB) begin
					wb_q <= cfg_data;
				end
			end
			if (state_q == ST_UPDATE) begin
				x_q <= x_q + dx_q;
				y_q <= y_q + dy_q;
				h_q <= h1_q;
			end
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_p;
		if (state_q == ST_IDLE && in_valid) begin
			sum_q <= SW'(sum_in);
			dif_q <= dif_in;
		end
		if (state_q == ST_MUL_MAG) begin
			lin_q <= lin_v;
		end
		if (state_q == ST_MUL_NH) begin
			mag_lo_q <= mag[23:0];
		end
		if (state_q == ST_MUL_NL) begin
			nacc_q <= DVW'({prod_q[MHW+29:0], 24'b0});
		end
		if (state_q == ST_ANG_WAIT && div_res.done) begin
			ang_q <= ang_v;
		end
		if (state_q == ST_BRANCH) begin
			h1_q <= h_q + ang_q;
		end
		if (state_q == ST_RK_WAIT && cor_res.done) begin
			fx_q <= 33'(cor_res.cos);
			fy_q <= 33'(cor_res.sin);
		end
		if (state_q == ST_ARC0_WAIT && cor_res.done) begin
			c0_q <= cor_res.cos;
			s0_q <= cor_res.sin;
		end
		if (state_q == ST_ARC1_WAIT && cor_res.done) begin
			c1_q <= cor_res.cos;
		end
		if (state_q == ST_ARC_MFY) begin
			numx_q <= prod_q;
		end
		if (state_q == ST_ARC_DX_GO) begin
			numy_q <= prod_q;
		end
		if (state_q == ST_ARC_DX_WAIT && div_res.done) begin
			fx_q <= f_v;
		end
		if (state_q == ST_ARC_DY_WAIT && div_res.done) begin
			fy_q <= f_v;
		end
		if (state_q == ST_MY) begin
			dx_q <= rnd_t[61:30];
		end
		if (state_q == ST_SY) begin
			dy_q <= rnd_t[61:30];
		end
		if (state_q == ST_FINISH && out_free) begin
			pos_x_q   <= x_q;
			pos_y_q   <= y_q;
			head_q    <= h_q;
			qz_q      <= to_q15(cor_res.sin);
			qw_q      <= to_q15(cor_res.cos);
			lin_out_q <= lin_q;
			ang_out_q <= ang_q;
		end
	end

	assign in_stall      = (state_q != ST_IDLE);
	assign out_valid     = out_valid_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign heading_angle = head_q;
	assign quat_z        = qz_q;
	assign quat_w        = qw_q;
	assign linear_step   = lin_out_q;
	assign angular_step  = ang_out_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != ST_IDLE))
		else $error("transaction accepted but sequencer stayed idle");

	a_rk_small_turn: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RK_WAIT) |-> (ang_q < 32'sd684 && ang_q > -32'sd684))
		else $error("midpoint path taken for a large turn");

	a_turn_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ANG_WAIT && div_res.done && div_res.ovf)
		|=> (ang_q == 32'sh7fff_ffff || ang_q == -32'sh7fff_ffff))
		else $error("turn rate overflow not saturated");

	a_cordic_owner: assert property (@(posedge clk) disable iff (!arst_n)
		cor_res.done |-> (state_q == ST_RK_WAIT || state_q == ST_ARC0_WAIT ||
		                  state_q == ST_ARC1_WAIT || state_q == ST_QWAIT))
		else $error("cordic finished outside a wait state");

endmodule

`default_nettype wire

>>> src/odo_cordic.sv
// ----------------------------------------------------------------------------
// odo_cordic
// iterative rotation cordic, one micro-rotation per cycle, gives sine and
// cosine of a binary angle in q1.30
// ----------------------------------------------------------------------------
`default_nettype none

module odo_cordic #(
	parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [31:0]         angle,
	output odo_pkg::cordic_res_t     res
);
	import odo_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 neg_q;
	logic [IW-1:0]        iter_q;
	logic                 busy_q, done_q;

	logic        neg;
	logic [31:0] b;
	logic signed [CW-1:0] dx, dy, at;
	logic        last;

	always_comb begin
		neg  = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
		b    = neg ? angle + 32'h8000_0000 : angle;
		dx   = y_q >>> iter_q;
		dy   = x_q >>> iter_q;
		at   = CW'($signed({1'b0, atan_entry(5'(iter_q))}));
		last = (iter_q == IW'(CORDIC_STEPS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && last) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			x_q    <= CW'($signed({1'b0, CORDIC_GAIN}));
			y_q    <= '0;
			z_q    <= CW'($signed(b));
			neg_q  <= neg;
			iter_q <= '0;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
			iter_q <= iter_q + 1'b1;
		end
	end

	assign res.done = done_q;
	assign res.cos  = neg_q ? -x_q : x_q;
	assign res.sin  = neg_q ? -y_q : y_q;

endmodule

`default_nettype wire

>>> src/odo_div.sv
// ----------------------------------------------------------------------------
// odo_div
// restoring divider, one quotient bit per cycle, with an overflow flag for
// quotients that do not fit the selected number of bits
// ----------------------------------------------------------------------------
`default_nettype none

module odo_div #(
	parameter int DIVIDEND_BITS = 71
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire odo_pkg::div_req_t        req,
	input  wire logic [DIVIDEND_BITS-1:0] dividend,
	input  wire logic [30:0]              divisor,
	output odo_pkg::div_res_t             res
);
	import odo_pkg::*;

	logic [30:0]          rem_q;
	logic [QUO_BITS-1:0]  dsh_q;
	logic [QUO_BITS-1:0]  quo_q;
	logic                 ovf_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q;

	logic [DIVIDEND_BITS-1:0] hi;
	logic [QUO_BITS-1:0]      dsh_init;
	logic [DIV_CNT_W-1:0]     cnt_init;
	logic                     ovf;
	logic [31:0]              t;
	logic                     ge;

	always_comb begin
		unique case (req.mode)
			DIV_ANG: begin
				hi       = dividend >> QUO_BITS;
				dsh_init = dividend[QUO_BITS-1:0];
				cnt_init = DIV_CNT_W'(QUO_BITS);
			end
			DIV_ARC: begin
				hi       = dividend >> ARC_QBITS;
				dsh_init = {dividend[ARC_QBITS-1:0], {(QUO_BITS-ARC_QBITS){1'b0}}};
				cnt_init = DIV_CNT_W'(ARC_QBITS);
			end
			default: begin
				hi       = '0;
				dsh_init = '0;
				cnt_init = '0;
			end
		endcase
		ovf = hi >= DIVIDEND_BITS'(divisor);
		t   = {rem_q, dsh_q[QUO_BITS-1]};
		ge  = t >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			rem_q <= hi[30:0];
			dsh_q <= dsh_init;
			quo_q <= '0;
			ovf_q <= ovf;
			cnt_q <= cnt_init;
		end else if (busy_q) begin
			rem_q <= ge ? 31'(t - {1'b0, divisor}) : t[30:0];
			quo_q <= {quo_q[QUO_BITS-2:0], ge};
			dsh_q <= dsh_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign res.done = done_q;
	assign res.ovf  = ovf_q;
	assign res.quo  = quo_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// odometry integrator testbench
// drives wheel encoder ticks through the valid/stall handshake, predicts the
// pose, heading quaternion and per-tick motion of every transaction, and
// compares each result field by field; registers are changed between phases
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import odo_pkg::*;

	typedef struct {
		logic signed [15:0] lf, rf, lr, rr;
	} tick_t;

	typedef struct {
		logic [31:0] x, y, hdg;
		logic [15:0] qz, qw;
		logic [31:0] lin, ang;
	} pose_t;

	localparam longint K_INV = 683565276;
	localparam longint GAIN  = 652032874;
	localparam longint ATAN [0:31] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
		5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
		10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};

	logic clk = 0, arst_n = 0;
	logic cfg_write = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 1;
	logic signed [15:0] vel_left_front = 0, vel_right_front = 0;
	logic signed [15:0] vel_left_rear = 0, vel_right_rear = 0;
	logic signed [31:0] pos_x, pos_y, linear_step, angular_step;
	logic [31:0] heading_angle;
	logic signed [15:0] quat_z, quat_w;

	diff_drive_odometry_integrator dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	tick_t pending_ticks[$];
	pose_t expected_poses[$];
	int errors = 0, sent = 0, received = 0, hold_cycles = 0;
	bit long_hold_done = 0;

	logic [23:0] mpt_reg, wb_reg;
	logic [31:0] x_acc, y_acc, h_acc;

	function automatic void cordic(input logic [31:0] a, output longint c, output longint s);
		logic [31:0] b;
		bit neg;
		longint x, y, z, dx, dy;
		b = a;
		neg = 0;
		if (a[31:30] == 2'd1 || a[31:30] == 2'd2) begin
			b = a + 32'h80000000;
			neg = 1;
		end
		z = longint'($signed(b));
		x = GAIN;
		y = 0;
		for (int i = 0; i < DEF_CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN[i];
			end else begin
				x += dx; y -= dy; z += ATAN[i];
			end
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic logic [15:0] to_q15(input longint v);
		longint t;
		t = (v + 16384) >>> 15;
		if (t > 32767) t = 32767;
		if (t < -32768) t = -32768;
		return t[15:0];
	endfunction

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic pose_t advance_pose(input tick_t t);
		pose_t p;
		longint sl, sr, lin, d, ang, dx, dy, fx, fy, c0, s0, c1, s1;
		logic [63:0] mag, q, r, amag, wb;
		logic [31:0] h1, dir;
		sl = longint'(t.lf) + longint'(t.lr);
		sr = -(longint'(t.rf) + longint'(t.rr));
		wb = wb_reg == 0 ? 64'd1 : 64'(wb_reg);
		lin = clip(((sl + sr) * longint'(mpt_reg) + 512) >>> 10,
		           -64'sd2147483648, 64'sd2147483647);
		d = sr - sl;
		mag = 64'(d < 0 ? -d : d) * 64'(mpt_reg);
		q = mag / wb;
		r = mag % wb;
		if (q >= 64'h1_0000_0000) amag = 2147483647;
		else begin
			amag = (q * K_INV + (r * K_INV) / wb + 256) >> 9;
			if (amag > 2147483647) amag = 2147483647;
		end
		ang = d < 0 ? -longint'(amag) : longint'(amag);
		h1 = h_acc + ang[31:0];
		if (ang < ARC_MIN && ang > -ARC_MIN) begin
			dir = h_acc + 32'(ang >>> 1);
			cordic(dir, c0, s0);
			dx = (lin * c0 + (64'sd1 <<< 29)) >>> 30;
			dy = (lin * s0 + (64'sd1 <<< 29)) >>> 30;
		end else begin
			cordic(h_acc, c0, s0);
			cordic(h1, c1, s1);
			fx = clip(((s1 - s0) * K_INV) / ang, -64'sd2147483648, 64'sd2147483648);
			fy = clip(((c0 - c1) * K_INV) / ang, -64'sd2147483648, 64'sd2147483648);
			dx = (lin * fx + (64'sd1 <<< 29)) >>> 30;
			dy = (lin * fy + (64'sd1 <<< 29)) >>> 30;
		end
		x_acc += dx[31:0];
		y_acc += dy[31:0];
		h_acc = h1;
		cordic(h_acc >> 1, c0, s0);
		p.x = x_acc;
		p.y = y_acc;
		p.hdg = h_acc;
		p.qz = to_q15(s0);
		p.qw = to_q15(c0);
		p.lin = lin[31:0];
		p.ang = ang[31:0];
		return p;
	endfunction

	// driver
	always @(posedge clk) begin
		logic nv;
		tick_t t;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				t.lf = vel_left_front; t.rf = vel_right_front;
				t.lr = vel_left_rear; t.rr = vel_right_rear;
				expected_poses.push_back(advance_pose(t));
				sent++;
				nv = 0;
			end
			if (!nv && pending_ticks.size() > 0 &&
			    ((sent > 400 && sent < 560) || $urandom_range(0, 99) >= 12)) begin
				t = pending_ticks.pop_front();
				vel_left_front <= t.lf; vel_right_front <= t.rf;
				vel_left_rear <= t.lr; vel_right_rear <= t.rr;
				nv = 1;
			end
		end
		in_valid <= nv;
	end

	function automatic void check_field(input string name, input logic [31:0] e,
	                                    input logic [31:0] a);
		if (e !== a) begin
			$error("%s expected %h got %h", name, e, a);
			errors++;
		end
	endfunction

	// monitor
	always @(posedge clk) begin
		pose_t p;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_poses.size() == 0) begin
					$error("unexpected transaction pos_x %h", pos_x);
					errors++;
				end else begin
					p = expected_poses.pop_front();
					check_field("pos_x", p.x, pos_x);
					check_field("pos_y", p.y, pos_y);
					check_field("heading_angle", p.hdg, heading_angle);
					check_field("quat_z", {16'd0, p.qz}, {16'd0, quat_z});
					check_field("quat_w", {16'd0, p.qw}, {16'd0, quat_w});
					check_field("linear_step", p.lin, linear_step);
					check_field("angular_step", p.ang, angular_step);
				end
				received++;
			end
			if (!long_hold_done && received == 120) begin
				long_hold_done = 1;
				hold_cycles = 3000;
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1;
			end else
				out_stall <= !(received > 250 && received < 420) && $urandom_range(0, 99) < 12;
		end
	end

	task automatic drain();
		while (pending_ticks.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_regs(input logic [23:0] mpt, input logic [23:0] wb);
		cfg_write <= 1; cfg_index <= REG_MPT; cfg_data <= mpt;
		@(posedge clk);
		cfg_index <= REG_WB; cfg_data <= wb;
		@(posedge clk);
		cfg_write <= 0;
		mpt_reg = mpt;
		wb_reg = wb;
		@(posedge clk);
	endtask

	task automatic add_tick(input int lf, input int rf, input int lr, input int rr);
		tick_t t;
		t.lf = 16'(lf); t.rf = 16'(rf); t.lr = 16'(lr); t.rr = 16'(rr);
		pending_ticks.push_back(t);
	endtask

	task automatic add_random_tick();
		int vl, vr, m;
		m = $urandom_range(0, 9);
		vl = int'($urandom_range(0, 600)) - 300;
		vr = int'($urandom_range(0, 600)) - 300;
		case (m)
			5: add_tick(vl, -vl, vl, -vl);
			6: add_tick(vl, -vl + int'($urandom_range(0, 2)) - 1, vl, -vl);
			7, 8, 9: add_tick($urandom, $urandom, $urandom, $urandom);
			default: add_tick(vl + int'($urandom_range(0, 4)) - 2, -vr,
			                  vl, -vr + int'($urandom_range(0, 4)) - 2);
		endcase
	endtask

	task automatic directed_set();
		add_tick(0, 0, 0, 0);
		add_tick(100, -100, 100, -100);
		add_tick(32767, -32768, 32767, -32768);
		add_tick(-32768, 32767, -32768, 32767);
		add_tick(32767, 32767, 32767, 32767);
		add_tick(-32768, -32768, -32768, -32768);
		add_tick(100, -101, 100, -100);
		add_tick(1, 0, 0, 0);
		add_tick(0, 1, 0, 0);
		add_tick(300, 300, 300, 300);
		add_tick(-300, -300, -300, -300);
		add_tick(32767, 0, 32767, 0);
		add_tick(16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
		add_tick(16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
		for (int i = 0; i < 6; i++)
			add_tick(20000, 20000, 20000, 20000);
	endtask

	initial begin
		mpt_reg = MPT_RESET;
		wb_reg = WB_RESET;
		x_acc = 0; y_acc = 0; h_acc = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed_set();
		drain();
		write_regs(24'hFFFFFF, 24'd1);
		directed_set();
		drain();
		write_regs(24'd1, 24'hFFFFFF);
		directed_set();
		drain();
		write_regs(24'd0, 24'd0);
		repeat (10) add_random_tick();
		drain();
		write_regs(MPT_RESET, WB_RESET);
		for (int i = 0; i < 300; i++) add_random_tick();
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			if (ph[0])
				write_regs(24'($urandom), 24'($urandom));
			else
				write_regs(24'($urandom_range(1, 200000)), 24'($urandom_range(1, 200000)));
			for (int i = 0; i < 110; i++) add_random_tick();
			drain();
		end
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
